### hw/rtl/ewhb_pkg.sv
// Shared types and constants for the equal-width histogram binner.
package ewhb_pkg;

    localparam int SAMPLE_W = 32;                  // Q16.16 sample and range_min
    localparam int WIDTH_W  = 31;                  // bin_width register
    localparam int NB_W     = 11;                  // num_bins register, search index
    localparam int SLACK_W  = 16;                  // top_slack register
    localparam int IDX_W    = 10;                  // bin_select / bin_index fields
    localparam int CNT_W    = 32;                  // bin count
    localparam int PROD_W   = 44;                  // index times width, plus slack
    localparam int STEP_W   = $clog2(NB_W);        // search step counter
    localparam int CFG_IW   = 2;                   // register index width
    localparam int CFG_DW   = 32;                  // register write data width

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_RANGE_MIN = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BIN_WIDTH = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_NUM_BINS  = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_TOP_SLACK = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [1:0]                 func;
        logic signed [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]           bin_select;
    } req_t;

    typedef struct packed {
        logic             in_range;
        logic [IDX_W-1:0] bin_index;
        logic [CNT_W-1:0] bin_count;
    } res_t;

    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] d;      // sample minus range_min, known nonnegative
        logic [WIDTH_W-1:0]  w;
        logic [NB_W-1:0]     last;   // highest bin in use
    } srch_req_t;

    typedef struct packed {
        logic              done;
        logic [NB_W-1:0]   k;
        logic [PROD_W-1:0] kw;       // k times bin width
    } srch_rsp_t;

endpackage

### hw/rtl/equal_width_histogram_binner_unit.sv
// Top level of the equal-width histogram binner: control, registers and count memory.
//
// Usage: requests arrive on req_valid/req_stall/req_data and results leave on
// res_valid/res_stall/res_data; a transfer happens when valid is high and stall
// is low. Every request produces exactly one result. func ADD counts a Q16.16
// sample into its bin, READ returns one bin's count, CLEAR zeroes all counts.
// Registers range_min, bin_width, num_bins, top_slack are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while no request is in
// flight, since the block itself does not enforce it. An ADD runs the 11-step
// halving search, one index bit per step, then a memory read and write-back; an
// ADD past the top edge ends after the search, and an ADD below the first edge,
// a READ of an unused bin or an unknown func goes straight to the output. READ
// does one memory read and CLEAR sweeps the whole count memory; one request is
// worked on at a time, so a new ADD is not taken before the last is through.
// Reset clears control state and starts a clearing pass over all MAX_BINS
// entries of the count memory; req_stall stays high during that pass.
// The result sits in an output register, so the next request is accepted as
// soon as the result is registered even when the receiver stalls; a further
// result then waits in the core until the output register frees up.
module equal_width_histogram_binner_unit #(
    parameter int MAX_BINS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  ewhb_pkg::req_t                req_data,
    output logic                          res_valid,
    input  logic                          res_stall,
    output ewhb_pkg::res_t                res_data,
    input  logic                          cfg_we,
    input  logic [ewhb_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [ewhb_pkg::CFG_DW-1:0]   cfg_data
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    // Configuration registers
    logic signed [ewhb_pkg::SAMPLE_W-1:0] range_min_reg;
    logic [ewhb_pkg::WIDTH_W-1:0]         bin_width_reg;
    logic [ewhb_pkg::NB_W-1:0]            num_bins_reg;
    logic [ewhb_pkg::SLACK_W-1:0]         top_slack_reg;

    // Control and request state
    logic [2:0]                     state_reg, state_next;
    logic [AW-1:0]                  clr_addr_reg, clr_addr_next;
    logic                           clr_res_reg, clr_res_next;
    logic [1:0]                     func_reg, func_next;
    logic [ewhb_pkg::NB_W-1:0]      idx_reg, idx_next;
    logic [ewhb_pkg::SAMPLE_W-1:0]  d_reg, d_next;
    ewhb_pkg::res_t                 res_reg, res_next;
    logic                           res_valid_reg, res_valid_next;
    ewhb_pkg::res_t                 res_data_reg, res_data_next;

    // Datapath
    logic [ewhb_pkg::NB_W-1:0]      n_use;
    logic [ewhb_pkg::NB_W-1:0]      last_bin;
    logic [ewhb_pkg::SAMPLE_W:0]    diff;
    logic                           below;
    logic [ewhb_pkg::PROD_W-1:0]    top_edge;
    logic                           top_hit;
    logic                           accept;
    logic                           out_free;
    logic [ewhb_pkg::CNT_W-1:0]     cnt_inc;

    ewhb_pkg::srch_req_t            srch_req;
    ewhb_pkg::srch_rsp_t            srch_rsp;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [ewhb_pkg::CNT_W-1:0]     ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [ewhb_pkg::CNT_W-1:0]     ram_rdata;

    // Bins in use: zero acts as one, clamp to the memory depth.
    always_comb
    begin
        if (num_bins_reg == '0)
        begin
            n_use = ewhb_pkg::NB_W'(1);
        end
        else if (32'(num_bins_reg) > MAX_BINS)
        begin
            n_use = ewhb_pkg::NB_W'(MAX_BINS);
        end
        else
        begin
            n_use = num_bins_reg;
        end
        last_bin = n_use - 1'b1;
    end

    // Offset of the sample from the first edge; below means a miss.
    assign diff  = {req_data.sample[ewhb_pkg::SAMPLE_W-1], req_data.sample} -
                   {range_min_reg[ewhb_pkg::SAMPLE_W-1], range_min_reg};
    assign below = diff[ewhb_pkg::SAMPLE_W];

    // Only the last bin can miss at the top: its edge is raised by the slack.
    assign top_edge = srch_rsp.kw + ewhb_pkg::PROD_W'(bin_width_reg) +
                      ewhb_pkg::PROD_W'(top_slack_reg);
    assign top_hit  = (srch_rsp.k != last_bin) ||
                      (ewhb_pkg::PROD_W'(d_reg) < top_edge);

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !res_valid_reg || !res_stall;
    assign cnt_inc   = (ram_rdata == ewhb_pkg::CNT_MAX) ? ram_rdata : ram_rdata + 1'b1;

    assign srch_req.start = accept && (req_data.func == ewhb_pkg::FUNC_ADD) && !below;
    assign srch_req.d     = d_reg;
    assign srch_req.w     = bin_width_reg;
    assign srch_req.last  = last_bin;

    ewhb_search u_search (
        .clk (clk),
        .rst_n (rst_n),
        .req (srch_req),
        .rsp (srch_rsp)
    );

    // Count memory: cleared by sweep, read-modify-write on add.
    always_comb
    begin
        ram_raddr = AW'(idx_reg);
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = (state_reg == S_UPDATE) && (func_reg == ewhb_pkg::FUNC_ADD);
            ram_waddr = AW'(idx_reg);
            ram_wdata = cnt_inc;
        end
    end

    ewhb_ram #(
        .WIDTH (ewhb_pkg::CNT_W),
        .DEPTH (MAX_BINS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_res_next   = clr_res_reg;
        func_next      = func_reg;
        idx_next       = idx_reg;
        d_next         = d_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;

        // Drop the output once the receiver takes it.
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(MAX_BINS - 1))
                begin
                    clr_addr_next = '0;
                    clr_res_next  = 1'b0;
                    if (clr_res_reg)
                    begin
                        res_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = req_data.func;
                    d_next    = diff[ewhb_pkg::SAMPLE_W-1:0];
                    idx_next  = {1'b0, req_data.bin_select};
                    res_next  = '0;
                    case (req_data.func)
                        ewhb_pkg::FUNC_ADD:
                        begin
                            state_next = below ? S_OUT : S_SEARCH;
                        end
                        ewhb_pkg::FUNC_READ:
                        begin
                            res_next.bin_index = req_data.bin_select;
                            if ({1'b0, req_data.bin_select} < n_use)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end
                        ewhb_pkg::FUNC_CLEAR:
                        begin
                            clr_addr_next = '0;
                            clr_res_next  = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (srch_rsp.done)
                begin
                    if (top_hit)
                    begin
                        idx_next   = srch_rsp.k;
                        state_next = S_READ;
                    end
                    else
                    begin
                        res_next   = '0;
                        state_next = S_OUT;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                res_next.in_range  = 1'b1;
                res_next.bin_index = idx_reg[ewhb_pkg::IDX_W-1:0];
                res_next.bin_count = (func_reg == ewhb_pkg::FUNC_ADD) ? cnt_inc : ram_rdata;
                state_next         = S_OUT;
            end
            S_OUT:
            begin
                // Hold the result until the output register frees up.
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            clr_res_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            range_min_reg <= '0;
            bin_width_reg <= ewhb_pkg::WIDTH_W'(65536);
            num_bins_reg  <= ewhb_pkg::NB_W'(1024);
            top_slack_reg <= ewhb_pkg::SLACK_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_res_reg   <= clr_res_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ewhb_pkg::CFG_RANGE_MIN: range_min_reg <= cfg_data;
                    ewhb_pkg::CFG_BIN_WIDTH:
                        bin_width_reg <= cfg_data[ewhb_pkg::WIDTH_W-1:0];
                    ewhb_pkg::CFG_NUM_BINS:
                        num_bins_reg <= cfg_data[ewhb_pkg::NB_W-1:0];
                    ewhb_pkg::CFG_TOP_SLACK:
                        top_slack_reg <= cfg_data[ewhb_pkg::SLACK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        idx_reg      <= idx_next;
        d_reg        <= d_next;
        res_reg      <= res_next;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> req_stall)
        else $error("request accepted during clearing pass");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR) || (state_reg == S_UPDATE))
        else $error("count memory written outside clear or update");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside output state");

endmodule

### hw/rtl/ewhb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ewhb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/ewhb_search.sv
// Halving search for the highest bin whose lower edge lies at or below the sample.
module ewhb_search (
    input  logic               clk,
    input  logic               rst_n,
    input  ewhb_pkg::srch_req_t req,
    output ewhb_pkg::srch_rsp_t rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [ewhb_pkg::STEP_W-1:0]   step_reg;
    logic [ewhb_pkg::NB_W-1:0]     k_reg;
    logic [ewhb_pkg::PROD_W-1:0]   kw_reg;

    logic [ewhb_pkg::NB_W-1:0]     trial_k;
    logic [ewhb_pkg::PROD_W-1:0]   trial_kw;
    logic                          take;

    // Try setting one more index bit; keep it if the edge is still below the sample.
    always_comb
    begin
        trial_k  = k_reg | (ewhb_pkg::NB_W'(1) << step_reg);
        trial_kw = kw_reg + (ewhb_pkg::PROD_W'(req.w) << step_reg);
        take     = (trial_k <= req.last) &&
                   (trial_kw <= ewhb_pkg::PROD_W'(req.d));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= ewhb_pkg::STEP_W'(ewhb_pkg::NB_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            k_reg  <= '0;
            kw_reg <= '0;
        end
        else if (busy_reg && take)
        begin
            k_reg  <= trial_k;
            kw_reg <= trial_kw;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.k    = k_reg;
    assign rsp.kw   = kw_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("search done while still busy");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (k_reg <= req.last) && (kw_reg <= ewhb_pkg::PROD_W'(req.d)))
        else $error("search index passed the last bin or the sample");

endmodule

### sim/testbench.sv
// Self-checking testbench for the equal-width histogram binner.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ewhb_pkg::*;

    localparam int         NUM_SLOTS = 1024;
    // func value with no defined operation; the block must answer with an empty result
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int         PRINT_CAP = 50;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    req_t              req_data;
    logic              res_valid;
    logic              res_stall;
    res_t              res_data;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    // Mirror of the block: bin counts and the four registers as last written.
    logic [CNT_W-1:0]           bin_tally [NUM_SLOTS];
    logic signed [SAMPLE_W-1:0] cur_range_min;
    logic [WIDTH_W-1:0]         cur_bin_width;
    logic [NB_W-1:0]            cur_num_bins;
    logic [SLACK_W-1:0]         cur_top_slack;

    // Results owed by the block, oldest first.
    res_t pending_results[$];

    int mismatch_count;
    int gap_pct;          // chance per request that the sender idles afterwards
    int stall_pct;        // chance per cycle that the receiver starts a stall burst
    int res_hold_cycles;  // long receiver hold-off, counted down by the receiver

    equal_width_histogram_binner_unit #(
        .MAX_BINS (NUM_SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop: several times the slowest legal run, including the clearing pass.
    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Bins in use: zero acts as one, anything above the memory size is clipped.
    function automatic int bins_active();
        int n;
        n = cur_num_bins;
        if (n == 0)
            n = 1;
        if (n > NUM_SLOTS)
            n = NUM_SLOTS;
        return n;
    endfunction

    // Work out the result of one request and update the mirrored counts.
    // Edges are compared in 64-bit arithmetic, so the top edge never wraps.
    function automatic res_t predict_bin_result(req_t r);
        res_t   res;
        longint lo;
        longint top;
        longint s;
        longint wid;
        longint k;
        int     n;
        res = '0;
        n   = bins_active();
        lo  = longint'(cur_range_min);
        wid = longint'(cur_bin_width);
        case (r.func)
            FUNC_ADD:
            begin
                s   = longint'(signed'(r.sample));
                top = lo + longint'(n) * wid + longint'(cur_top_slack);
                if (s >= lo && s < top)
                begin
                    // zero width sends every hit to the last bin; slack hits clip there too
                    k = (wid != 0) ? (s - lo) / wid : longint'(n - 1);
                    if (k > n - 1)
                        k = n - 1;
                    if (bin_tally[k] != CNT_MAX)
                        bin_tally[k] = bin_tally[k] + 1'b1;
                    res.in_range  = 1'b1;
                    res.bin_index = k[IDX_W-1:0];
                    res.bin_count = bin_tally[k];
                end
            end
            FUNC_READ:
            begin
                res.bin_index = r.bin_select;
                if (int'(r.bin_select) < n)
                begin
                    res.in_range  = 1'b1;
                    res.bin_count = bin_tally[r.bin_select];
                end
            end
            FUNC_CLEAR:
            begin
                foreach (bin_tally[i])
                    bin_tally[i] = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic req_t make_req(logic [1:0] func, logic [31:0] sample,
                                      logic [IDX_W-1:0] sel);
        req_t r;
        r.func       = func;
        r.sample     = sample;
        r.bin_select = sel;
        return r;
    endfunction

    // Sample biased toward the bins in use, the slack band and the lower edge;
    // the rest is drawn over the full 32-bit range.
    function automatic logic [31:0] pick_sample();
        longint lo;
        longint w;
        longint n;
        longint v;
        int     sel;
        lo  = longint'(cur_range_min);
        w   = longint'(cur_bin_width);
        n   = bins_active();
        sel = $urandom_range(0, 99);
        if (sel < 70)
            v = lo + longint'($urandom_range(0, n - 1)) * w
                   + ((w == 0) ? 0 : longint'($urandom_range(0, w - 1)));
        else if (sel < 80)
            v = lo + n * w + longint'($urandom_range(0, cur_top_slack));
        else if (sel < 85)
            v = lo - longint'($urandom_range(1, 4));
        else
            v = longint'($urandom);
        return v[31:0];
    endfunction

    task automatic report_issue(string msg);
        if (mismatch_count < PRINT_CAP)
            $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offer one request and hold it until accepted; then log what it should return.
    task automatic send_request(req_t r);
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= r;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        pending_results.push_back(predict_bin_result(r));
    endtask

    // Idle the sender now and then, for a gap drawn from a short range or, less often, a much longer one.
    task automatic idle_gap();
        int len;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (len - 1) @(negedge clk);
        end
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_for_drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_RANGE_MIN: cur_range_min = data;
            CFG_BIN_WIDTH: cur_bin_width = data[WIDTH_W-1:0];
            CFG_NUM_BINS:  cur_num_bins  = data[NB_W-1:0];
            CFG_TOP_SLACK: cur_top_slack = data[SLACK_W-1:0];
            default: ;
        endcase
    endtask

    // Reprogram all four registers, only once the block has gone idle.
    task automatic apply_config(logic [31:0] rm, logic [31:0] bw, logic [31:0] nb,
                                logic [31:0] sl);
        wait_for_drain();
        write_reg(CFG_RANGE_MIN, rm);
        write_reg(CFG_BIN_WIDTH, bw);
        write_reg(CFG_NUM_BINS, nb);
        write_reg(CFG_TOP_SLACK, sl);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random mix of adds, reads and the odd clear under the current registers.
    task automatic send_random_mix(int count);
        req_t r;
        int   pick;
        for (int i = 0; i < count; i++)
        begin
            r.sample     = $urandom;
            r.bin_select = $urandom;
            pick         = $urandom_range(0, 199);
            if (pick == 0)
                r.func = FUNC_CLEAR;
            else if (pick < 45)
            begin
                r.func = FUNC_READ;
                if ($urandom_range(0, 99) < 60)
                    r.bin_select = $urandom_range(0, bins_active() - 1);
            end
            else
            begin
                r.func   = FUNC_ADD;
                r.sample = pick_sample();
            end
            send_request(r);
            idle_gap();
        end
    endtask

    // Reset registers: unit-wide bins from zero, one LSB of slack on top.
    // Hit both ends of the bin range, the slack band, misses on either side,
    // a read of the last bin, the undefined func, then a clear and a read-back.
    task automatic test_reset_defaults();
        send_request(make_req(FUNC_READ, 32'd0, 10'd0));
        send_request(make_req(FUNC_ADD, 32'd0, 10'd0));
        send_request(make_req(FUNC_ADD, 32'h03FF_FFFF, 10'd0));
        send_request(make_req(FUNC_ADD, 32'h0400_0000, 10'd0));
        send_request(make_req(FUNC_ADD, 32'h0400_0001, 10'd0));
        send_request(make_req(FUNC_ADD, 32'hFFFF_FFFF, 10'd0));
        send_request(make_req(FUNC_ADD, 32'h7FFF_FFFF, 10'd0));
        send_request(make_req(FUNC_READ, 32'd0, 10'h3FF));
        send_request(make_req(FUNC_NONE, 32'hFFFF_FFFF, 10'h3FF));
        send_request(make_req(FUNC_CLEAR, 32'd0, 10'd0));
        send_request(make_req(FUNC_READ, 32'd0, 10'h3FF));
    endtask

    // Register extremes: one bin of maximum width from the most negative edge,
    // zero width with a zero bin count, and the bin count above the memory size.
    task automatic test_register_extremes();
        apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd65535);
        send_request(make_req(FUNC_ADD, 32'h8000_0000, 10'd0));
        send_request(make_req(FUNC_ADD, 32'd65533, 10'd0));
        send_request(make_req(FUNC_ADD, 32'd65534, 10'd0));
        send_request(make_req(FUNC_ADD, 32'h7FFF_FFFF, 10'd0));
        send_request(make_req(FUNC_READ, 32'd0, 10'd1));

        // only the slack band is live here
        apply_config(32'd500, 32'd0, 32'd0, 32'd100);
        send_request(make_req(FUNC_ADD, 32'd599, 10'd0));
        send_request(make_req(FUNC_ADD, 32'd600, 10'd0));
        send_request(make_req(FUNC_ADD, 32'd499, 10'd0));

        // the top edge lands just past the largest sample
        apply_config(32'h7FFF_FC00, 32'd1, 32'd2047, 32'd0);
        send_request(make_req(FUNC_ADD, 32'h7FFF_FFFF, 10'd0));
        send_request(make_req(FUNC_ADD, 32'h7FFF_FC00, 10'd0));
        send_request(make_req(FUNC_READ, 32'd0, 10'h3FF));
    endtask

    // Block the output for a long stretch while requests keep coming, so the
    // core fills and stalls its input; then pause the sender until drained,
    // and finish with a run with no idling on either side.
    task automatic test_backpressure();
        apply_config(32'hFFFF_0000, 32'd8192, 32'd32, 32'd0);
        gap_pct         = 0;
        stall_pct       = 0;
        res_hold_cycles = 300;
        send_random_mix(24);
        wait_for_drain();
        send_random_mix(40);
    endtask

    // Random phases, each with fresh registers and its own idle rates.
    task automatic test_random_mix();
        logic [31:0] rm;
        logic [31:0] bw;
        logic [31:0] nb;
        logic [31:0] sl;
        for (int p = 0; p < 6; p++)
        begin
            rm = $urandom;
            sl = $urandom_range(0, 65535);
            case (p % 4)
                0:
                begin
                    bw = $urandom_range(1, 1 << 16);
                    nb = $urandom_range(1, 64);
                end
                1:
                begin
                    rm = 32'hFE00_0000 + $urandom_range(0, 65535);
                    bw = 32'd65536;
                    nb = 32'd1024;
                    sl = $urandom_range(0, 3);
                end
                2:
                begin
                    bw = $urandom_range(1, 32'h7FFF_FFFF);
                    nb = $urandom_range(0, 4);
                end
                default:
                begin
                    bw = $urandom_range(0, 16);
                    nb = $urandom_range(1, 2047);
                end
            endcase
            apply_config(rm, bw, nb, sl);
            gap_pct   = (p == 0) ? 0 : $urandom_range(10, 40);
            stall_pct = (p == 0) ? 0 : $urandom_range(10, 40);
            send_random_mix(140);
        end
    endtask

    // Receiver: a pending hold-off wins, then the current burst, then a coin toss.
    initial
    begin
        int burst;
        burst     = 0;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (res_hold_cycles > 0)
            begin
                res_stall <= 1'b1;
                res_hold_cycles--;
            end
            else if (burst > 0)
            begin
                res_stall <= 1'b1;
                burst--;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                burst     = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 2);
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // Check every accepted result against the oldest owed one, field by field.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
                report_issue($sformatf("result with nothing pending: %h", res_data));
            else
            begin
                want = pending_results.pop_front();
                if (res_data.in_range !== want.in_range)
                    report_issue($sformatf("in_range: want %0d got %0d",
                                           want.in_range, res_data.in_range));
                if (res_data.bin_index !== want.bin_index)
                    report_issue($sformatf("bin_index: want %0d got %0d",
                                           want.bin_index, res_data.bin_index));
                if (res_data.bin_count !== want.bin_count)
                    report_issue($sformatf("bin_count: want %0d got %0d",
                                           want.bin_count, res_data.bin_count));
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req_data        = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        gap_pct         = 0;
        stall_pct       = 0;
        res_hold_cycles = 0;
        mismatch_count  = 0;
        cur_range_min   = '0;
        cur_bin_width   = WIDTH_W'(65536);
        cur_num_bins    = NB_W'(1024);
        cur_top_slack   = SLACK_W'(1);
        foreach (bin_tally[i])
            bin_tally[i] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // requests wait out the clearing pass through req_stall
        test_reset_defaults();
        test_register_extremes();
        test_backpressure();
        test_random_mix();

        wait_for_drain();
        // let any stray extra result show up before the verdict
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
